@@ hdl/tgq_pkg.sv @@
// tgq_pkg: shared types, constants and status codes for the team grouped queue.
// No dependencies.
`timescale 1ns / 1ps
package tgq_pkg;

  localparam int ELEMENT_BITS_DEF = 10;
  localparam int MAX_TEAMS_DEF    = 64;
  localparam int QUEUE_DEPTH_DEF  = 1024;

  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 7;
  localparam int TEAM_IN_W = 6;
  localparam int OUT_VAL_W = 10;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD    = 2'd0,
    FN_ENQUEUE = 2'd1,
    FN_DEQUEUE = 2'd2,
    FN_CLEAR   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_NO_TEAM = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_FULL    = 3'd3,
    ST_RANGE   = 3'd4
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the input item
    logic clr_step;  // write one row of the clearing pass
    logic clr_start; // restart clearing counter
    logic rd;        // membership, order ring and free list reads
    logic rd_chain;  // team chain ends of the selected team
    logic rd_node;   // value and link of the team's first node
    logic exec;      // apply writes and produce the result
  } tgq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done;
  } tgq_stat_t;

endpackage

@@ hdl/tgq_ctrl.sv @@
// tgq_ctrl: sequencing state machine for the team grouped queue.
// Depends on tgq_pkg.
`timescale 1ns / 1ps
module tgq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         in_func,
  input  tgq_pkg::tgq_stat_t stat,
  output tgq_pkg::tgq_cmd_t  cmd,
  output logic               busy
);
  import tgq_pkg::*;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_CHAIN, S_NODE, S_EXEC} state_t;

  state_t state_r, state_nxt;
  logic   busy_nxt;
  logic   accept;

  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.capture = accept;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (func_t'(in_func) == FN_CLEAR) begin
            state_nxt     = S_CLEAR;
            cmd.clr_start = 1'b1;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CHAIN;
      end
      S_CHAIN: begin
        cmd.rd_chain = 1'b1;
        state_nxt    = S_NODE;
      end
      S_NODE: begin
        cmd.rd_node = 1'b1;
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy    <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy    <= busy_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_read_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |=> state_r == S_CHAIN) else $error("read not followed by chain read");
  a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    busy == (state_r != S_IDLE)) else $error("busy disagrees with state");
  a_exec_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |=> !busy) else $error("exec not followed by idle");
`endif
endmodule

@@ hdl/tgq_datapath.sv @@
// tgq_datapath: membership table, node store, team chains and order ring.
// Depends on tgq_pkg.
`timescale 1ns / 1ps
module tgq_datapath #(
  parameter int ELEMENT_BITS = tgq_pkg::ELEMENT_BITS_DEF,
  parameter int MAX_TEAMS    = tgq_pkg::MAX_TEAMS_DEF,
  parameter int QUEUE_DEPTH  = tgq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tgq_pkg::tgq_cmd_t         cmd,
  output tgq_pkg::tgq_stat_t        stat,
  input  logic [1:0]                in_func,
  input  logic [ELEMENT_BITS-1:0]   in_elem_value,
  input  logic [5:0]                in_team_in,
  input  logic                      cfg_we,
  input  logic [6:0]                cfg_teams_in_use,
  output logic [ELEMENT_BITS-1:0]   out_value,
  output logic                      out_valid,
  output logic [2:0]                out_status,
  output logic                      done
);
  import tgq_pkg::*;

  localparam int VSPAN = 1 << ELEMENT_BITS;
  localparam int TW    = (MAX_TEAMS > 1) ? $clog2(MAX_TEAMS) : 1;
  localparam int MTW   = $clog2(MAX_TEAMS + 1);
  localparam int NW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SWEEP = (VSPAN > QUEUE_DEPTH) ? VSPAN : QUEUE_DEPTH;
  localparam int SW    = $clog2(SWEEP);
  localparam int LIMW  = (MTW > 7) ? MTW : 7;

  // memories
  logic [MTW-1:0]          mem_team [VSPAN];
  logic [ELEMENT_BITS-1:0] mem_val  [QUEUE_DEPTH];
  logic [NW-1:0]           mem_link [QUEUE_DEPTH];
  logic [NW-1:0]           mem_first[MAX_TEAMS];
  logic [NW-1:0]           mem_last [MAX_TEAMS];
  logic [TW-1:0]           mem_ring [MAX_TEAMS];

  logic [MAX_TEAMS-1:0] waiting_r;
  logic [NW-1:0]        free_head_r;
  logic [TW-1:0]        front_r, back_r;
  logic [CW-1:0]        held_r;
  logic [6:0]           teams_r;
  logic [SW:0]          clr_cnt_r;

  logic [1:0]              func_r;
  logic [ELEMENT_BITS-1:0] elem_r;
  logic [5:0]              team_r;

  // registered read data, one stage per dependent lookup
  logic [MTW-1:0]          rd_team_r;
  logic [TW-1:0]           rd_ring_r;
  logic [NW-1:0]           rd_freelink_r;
  logic [NW-1:0]           rd_first_r;
  logic [NW-1:0]           rd_last_r;
  logic [ELEMENT_BITS-1:0] rd_val_r;
  logic [NW-1:0]           rd_link_r;

  logic [TW-1:0] enq_team;
  logic [TW-1:0] chain_team;
  assign enq_team   = rd_team_r[TW-1:0];
  // dequeue follows the front team of the ring, enqueue the element's team
  assign chain_team = (func_t'(func_r) == FN_DEQUEUE) ? rd_ring_r : enq_team;

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_team_r     <= mem_team[elem_r];
      rd_ring_r     <= mem_ring[front_r];
      rd_freelink_r <= mem_link[free_head_r];
    end
    if (cmd.rd_chain) begin
      rd_first_r <= mem_first[chain_team];
      rd_last_r  <= mem_last[chain_team];
    end
    if (cmd.rd_node) begin
      rd_val_r  <= mem_val[rd_first_r];
      rd_link_r <= mem_link[rd_first_r];
    end
  end

  logic                  lim_ok;
  logic [LIMW-1:0]       limit;
  assign limit  = (LIMW'(teams_r) < LIMW'(MAX_TEAMS)) ? LIMW'(teams_r) : LIMW'(MAX_TEAMS);
  assign lim_ok = LIMW'(team_r) < limit;

  logic enq_known, q_full, q_empty;
  assign enq_known = (rd_team_r < MTW'(MAX_TEAMS));
  assign q_full    = (held_r == CW'(QUEUE_DEPTH));
  assign q_empty   = (held_r == '0);

  logic do_enq, do_deq, do_load;
  assign do_load = cmd.exec && func_t'(func_r) == FN_LOAD && lim_ok;
  assign do_enq  = cmd.exec && func_t'(func_r) == FN_ENQUEUE && enq_known && !q_full;
  assign do_deq  = cmd.exec && func_t'(func_r) == FN_DEQUEUE && !q_empty;

  logic deq_single;
  assign deq_single = (rd_first_r == rd_last_r);

  logic [TW-1:0] ring_nb, ring_nf;
  assign ring_nb = (int'(back_r) + 1 >= MAX_TEAMS) ? '0 : back_r + 1'b1;
  assign ring_nf = (int'(front_r) + 1 >= MAX_TEAMS) ? '0 : front_r + 1'b1;

  logic clearing;
  assign clearing = cmd.clr_step;
  assign stat.clr_done = (clr_cnt_r == (SW+1)'(SWEEP - 1));

  // free link for clear sweep
  logic [NW-1:0] sweep_link;
  assign sweep_link = (int'(clr_cnt_r) + 1 >= QUEUE_DEPTH) ? '0 : NW'(clr_cnt_r + 1'b1);

  // single write port per memory
  logic          link_we, first_we;
  logic [NW-1:0] link_addr, link_din, first_din;
  logic [TW-1:0] first_addr;

  always_comb begin
    link_we   = 1'b0;
    link_addr = rd_first_r;
    link_din  = free_head_r;
    if (clearing) begin
      link_we   = (int'(clr_cnt_r) < QUEUE_DEPTH);
      link_addr = clr_cnt_r[NW-1:0];
      link_din  = sweep_link;
    end else if (do_enq) begin
      link_we   = waiting_r[enq_team];
      link_addr = rd_last_r;
    end else if (do_deq) begin
      link_we   = 1'b1;
    end
    first_we   = (do_enq && !waiting_r[enq_team]) || (do_deq && !deq_single);
    first_addr = do_deq ? rd_ring_r : enq_team;
    first_din  = do_deq ? rd_link_r : free_head_r;
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      if (int'(clr_cnt_r) < VSPAN) mem_team[clr_cnt_r[ELEMENT_BITS-1:0]] <= MTW'(MAX_TEAMS);
    end else if (do_load) begin
      mem_team[elem_r] <= MTW'(team_r);
    end
    if (link_we) mem_link[link_addr] <= link_din;
    if (first_we) mem_first[first_addr] <= first_din;
    if (do_enq) begin
      mem_val[free_head_r] <= elem_r;
      mem_last[enq_team]   <= free_head_r;
      if (!waiting_r[enq_team]) mem_ring[back_r] <= enq_team;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      func_r      <= FN_LOAD;
      elem_r      <= '0;
      team_r      <= '0;
      waiting_r   <= '0;
      free_head_r <= '0;
      front_r     <= '0;
      back_r      <= '0;
      held_r      <= '0;
      teams_r     <= 7'd64;
      clr_cnt_r   <= '0;
      done        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.capture) begin
        func_r <= in_func;
        elem_r <= in_elem_value;
        team_r <= in_team_in;
      end
      if (cfg_we) teams_r <= cfg_teams_in_use;
      done <= cmd.exec || (clearing && stat.clr_done && func_t'(func_r) == FN_CLEAR);
      out_valid <= do_deq;
      if (cmd.clr_start) clr_cnt_r <= '0;
      else if (clearing) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.clr_start) begin
        waiting_r   <= '0;
        free_head_r <= '0;
        front_r     <= '0;
        back_r      <= '0;
        held_r      <= '0;
      end else if (do_enq) begin
        free_head_r <= rd_freelink_r;
        held_r      <= held_r + 1'b1;
        if (!waiting_r[enq_team]) begin
          waiting_r[enq_team] <= 1'b1;
          back_r <= ring_nb;
        end
      end else if (do_deq) begin
        free_head_r <= rd_first_r;
        held_r      <= held_r - 1'b1;
        if (deq_single) begin
          waiting_r[rd_ring_r] <= 1'b0;
          front_r <= ring_nf;
        end
      end
    end
  end

  status_t status_nxt;

  always_comb begin
    case (func_t'(func_r))
      FN_LOAD:    status_nxt = lim_ok ? ST_OK : ST_RANGE;
      FN_ENQUEUE: status_nxt = !enq_known ? ST_NO_TEAM : (q_full ? ST_FULL : ST_OK);
      FN_DEQUEUE: status_nxt = q_empty ? ST_EMPTY : ST_OK;
      default:    status_nxt = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    out_value  <= do_deq ? rd_val_r : '0;
    out_status <= cmd.exec ? status_nxt : ST_OK;
  end

`ifndef ASSERT_OFF
  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(QUEUE_DEPTH)) else $error("held count overflow");
  a_deq_valid: assert property (@(posedge clk) disable iff (!rst_n)
    do_deq |=> out_valid && done) else $error("dequeue without valid result");
  a_enq_deq_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(do_enq && do_deq)) else $error("enqueue and dequeue together");
`endif
endmodule

@@ hdl/team_grouped_queue_core.sv @@
// Team grouped queue: membership table, team chains and team order ring. An item
// is taken when start is high and busy is low. Dependent memory reads
// (membership and ring front, then the team's chain ends, then the head node)
// and an update step follow; the result is registered onto the out ports with
// out_strobe, and busy falls in the cycle of out_strobe, so no new item is
// taken before the last one is done. A clear item, and reset, run a clearing
// pass over the membership table and free list of max(2^ELEMENT_BITS, QUEUE_DEPTH)
// rows; the clear result follows in the next cycle. The receiver cannot stall.
// Depends on tgq_pkg, tgq_ctrl, tgq_datapath.
`timescale 1ns / 1ps
module team_grouped_queue_core #(
  parameter int ELEMENT_BITS = tgq_pkg::ELEMENT_BITS_DEF,
  parameter int MAX_TEAMS    = tgq_pkg::MAX_TEAMS_DEF,
  parameter int QUEUE_DEPTH  = tgq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_func,
  input  logic [ELEMENT_BITS-1:0] in_elem_value,
  input  logic [5:0]              in_team_in,
  input  logic                    cfg_we,
  input  logic [6:0]              cfg_teams_in_use,
  output logic                    out_strobe,
  output logic [ELEMENT_BITS-1:0] out_value,
  output logic                    out_valid,
  output logic [2:0]              out_status
);
  import tgq_pkg::*;

  tgq_cmd_t  cmd;
  tgq_stat_t stat;

  tgq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_func(in_func),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  tgq_datapath #(
    .ELEMENT_BITS(ELEMENT_BITS), .MAX_TEAMS(MAX_TEAMS), .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_func(in_func), .in_elem_value(in_elem_value), .in_team_in(in_team_in),
    .cfg_we(cfg_we), .cfg_teams_in_use(cfg_teams_in_use),
    .out_value(out_value), .out_valid(out_valid), .out_status(out_status),
    .done(out_strobe)
  );
endmodule
